// ===== sv/rde_pkg.sv =====
`timescale 1ns / 1ps
package rde_pkg;

   localparam int VALUE_BITS    = 64;
   localparam int DIV_STEP_BITS = 8;
   localparam int DIV_CYCLES    = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
   localparam int DIV_BITS      = DIV_CYCLES * DIV_STEP_BITS;
   localparam int MAX_DIGITS    = VALUE_BITS;
   localparam int STACK_BITS    = MAX_DIGITS * 4;
   localparam int CNT_BITS      = $clog2(MAX_DIGITS + 1);
   localparam int STEP_BITS     = $clog2(DIV_CYCLES + 1);

   localparam logic [4:0] RADIX_MIN = 5'd2;
   localparam logic [4:0] RADIX_MAX = 5'd16;

   localparam logic [6:0] ASCII_ZERO   = 7'd48;
   localparam logic [6:0] ASCII_LETTER = 7'd55;

   typedef struct packed {
      logic [63:0] value;
      logic [4:0]  radix;
   } req_type;

   typedef struct packed {
      logic [6:0] digit_char;
      logic       last_digit;
      logic       bad_radix;
   } rsp_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [4:0]            radix;
      logic [3:0]            digit_mask;
      logic [2:0]            shift;
      logic                  pow2;
      logic                  bad;
   } job_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } back_state_type;

endpackage

// ===== sv/radix_digit_emitter.sv =====
`timescale 1ns / 1ps
// A request is registered in the front end, buffered in the 2-entry queue and taken by the
// back end when idle; bases 2, 4, 8, 16 take each digit by shift and mask, others by an
// 8-bit-per-cycle restoring divider; digits are stacked, sent most significant first, one
// digit per cycle unless rsp_stall holds it; a bad base gives one beat with bad_radix set;
// the back end takes a new job only after its last beat; the queue decouples the ends
// reset is synchronous, active high, and clears all control state; no clearing pass
module radix_digit_emitter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rde_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rde_pkg::rsp_type rsp_data
);
   import rde_pkg::*;

   logic    front_valid, front_stall;
   job_type front_job;
   logic    back_valid, back_stall;
   job_type back_job;

   rde_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .job_valid (front_valid),
      .job_stall (front_stall),
      .job_data  (front_job)
   );

   rde_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_stall  (front_stall),
      .in_data   (front_job),
      .out_valid (back_valid),
      .out_stall (back_stall),
      .out_data  (back_job)
   );

   rde_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (back_valid),
      .job_stall (back_stall),
      .job_data  (back_job),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/rde_front.sv =====
`timescale 1ns / 1ps
module rde_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rde_pkg::req_type req_data,
   output logic             job_valid,
   input  logic             job_stall,
   output rde_pkg::job_type job_data
);
   import rde_pkg::*;

   logic    valid_ff, valid_in;
   job_type job_ff, job_in;
   logic    load;
   logic    bad;
   logic [2:0] shift;

   always_comb begin
      unique case (req_data.radix)
         5'd2:    shift = 3'd1;
         5'd4:    shift = 3'd2;
         5'd8:    shift = 3'd3;
         5'd16:   shift = 3'd4;
         default: shift = 3'd0;
      endcase
   end

   assign bad = (req_data.radix < RADIX_MIN) || (req_data.radix > RADIX_MAX);

   always_comb begin
      job_in.value      = req_data.value[VALUE_BITS-1:0];
      job_in.radix      = req_data.radix;
      job_in.digit_mask = req_data.radix[3:0] - 4'd1;
      job_in.shift      = shift;
      job_in.pow2       = (shift != 3'd0);
      job_in.bad        = bad;
   end

   assign req_stall = valid_ff && job_stall;
   assign load      = !valid_ff || !job_stall;
   assign valid_in  = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load && req_valid) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = valid_ff;
   assign job_data  = job_ff;

endmodule

// ===== sv/rde_queue.sv =====
`timescale 1ns / 1ps
module rde_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_stall,
   input  rde_pkg::job_type in_data,
   output logic             out_valid,
   input  logic             out_stall,
   output rde_pkg::job_type out_data
);
   import rde_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_stall  = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];

   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== sv/rde_back.sv =====
`timescale 1ns / 1ps
module rde_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_stall,
   input  rde_pkg::job_type job_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rde_pkg::rsp_type rsp_data
);
   import rde_pkg::*;

   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DIV_CYCLES - 1);

   back_state_type state_ff, state_in;

   logic [DIV_BITS-1:0]   work_ff, work_in;
   logic [3:0]            rem_ff, rem_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [STACK_BITS-1:0] stack_ff, stack_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [4:0]            radix_ff, radix_in;
   logic [3:0]            mask_ff, mask_in;
   logic [2:0]            shift_ff, shift_in;
   logic                  pow2_ff, pow2_in;
   logic                  err_ff, err_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [DIV_BITS-1:0] div_q;
   logic [3:0]          div_r;
   logic [DIV_BITS-1:0] pow2_q;
   logic [3:0]          pow2_r;
   logic                digit_done;
   logic                quot_zero;
   logic                out_free;
   logic [3:0]          push_digit;

   function automatic logic [6:0] to_ascii(input logic [3:0] d);
      logic [6:0] wide;
      wide = {3'd0, d};
      return (d < 4'd10) ? (ASCII_ZERO + wide) : (ASCII_LETTER + wide);
   endfunction

   // eight restoring division steps per cycle
   always_comb begin
      logic [DIV_BITS-1:0] q;
      logic [4:0]          r5;
      logic [3:0]          r;
      q  = work_ff;
      r  = rem_ff;
      r5 = 5'd0;
      for (int i = 0; i < DIV_STEP_BITS; i++) begin
         r5 = {r, q[DIV_BITS-1]};
         q  = {q[DIV_BITS-2:0], 1'b0};
         if (r5 >= radix_ff) begin
            r5   = r5 - radix_ff;
            q[0] = 1'b1;
         end
         r = r5[3:0];
      end
      div_q = q;
      div_r = r;
   end

   assign pow2_q = work_ff >> shift_ff;
   assign pow2_r = work_ff[3:0] & mask_ff;

   assign digit_done = pow2_ff || (step_ff == LAST_STEP);
   assign quot_zero  = pow2_ff ? (pow2_q == '0) : (div_q == '0);
   assign push_digit = pow2_ff ? pow2_r : div_r;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               state_in = job_data.bad ? ST_EMIT : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (digit_done && quot_zero) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && (err_ff || (count_ff == CNT_BITS'(1)))) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      job_stall    = 1'b1;
      work_in      = work_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      stack_in     = stack_ff;
      count_in     = count_ff;
      radix_in     = radix_ff;
      mask_in      = mask_ff;
      shift_in     = shift_ff;
      pow2_in      = pow2_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            job_stall = 1'b0;
            if (job_valid) begin
               work_in  = DIV_BITS'(job_data.value);
               rem_in   = 4'd0;
               step_in  = '0;
               count_in = '0;
               radix_in = job_data.radix;
               mask_in  = job_data.digit_mask;
               shift_in = job_data.shift;
               pow2_in  = job_data.pow2;
               err_in   = job_data.bad;
            end
         end
         ST_DIVIDE: begin
            if (pow2_ff) begin
               work_in = pow2_q;
            end else begin
               work_in = div_q;
               rem_in  = div_r;
               step_in = step_ff + STEP_BITS'(1);
            end
            if (digit_done) begin
               rem_in   = 4'd0;
               step_in  = '0;
               stack_in = {stack_ff[STACK_BITS-5:0], push_digit};
               count_in = count_ff + CNT_BITS'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (err_ff) begin
                  rsp_in.digit_char = 7'd0;
                  rsp_in.last_digit = 1'b1;
                  rsp_in.bad_radix  = 1'b1;
               end else begin
                  rsp_in.digit_char = to_ascii(stack_ff[3:0]);
                  rsp_in.last_digit = (count_ff == CNT_BITS'(1));
                  rsp_in.bad_radix  = 1'b0;
                  stack_in          = {4'd0, stack_ff[STACK_BITS-1:4]};
                  count_in          = count_ff - CNT_BITS'(1);
               end
            end
         end
         default: begin
            job_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      stack_ff <= stack_in;
      radix_ff <= radix_in;
      mask_ff  <= mask_in;
      shift_ff <= shift_in;
      pow2_ff  <= pow2_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
